// ===== design/irpt_pkg.sv =====
// Shared constants and codes for the IR pulse-train emitter.
package irpt_pkg;

  // Parameter defaults
  localparam int unsigned BufferDepthDef = 256;
  localparam int unsigned NecBitsDef     = 32;
  localparam int unsigned SkyBitsDef     = 12;

  // Field widths
  localparam int unsigned CmdW    = 3;
  localparam int unsigned CodeW   = 32;
  localparam int unsigned SlotW   = 8;
  localparam int unsigned DurW    = 16;
  localparam int unsigned RawLenW = 9;

  // Configuration register file
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgCount = 8;

  localparam logic [CfgIdxW-1:0] CFG_NEC_LEAD_HIGH  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_NEC_LEAD_LOW   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_NEC_MARK       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_NEC_SPACE_ZERO = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NEC_SPACE_ONE  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SKY_START      = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SKY_ZERO       = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SKY_ONE        = 3'd7;

  localparam logic [DurW-1:0] CFG_RESET [CfgCount] = '{
    16'd450, 16'd450, 16'd56, 16'd56, 16'd169, 16'd600, 16'd60, 16'd120
  };

  // Command codes
  localparam logic [CmdW-1:0] CMD_TICK   = 3'd0;
  localparam logic [CmdW-1:0] CMD_NEC    = 3'd1;
  localparam logic [CmdW-1:0] CMD_SKY    = 3'd2;
  localparam logic [CmdW-1:0] CMD_RAW_WR = 3'd3;
  localparam logic [CmdW-1:0] CMD_RAW_GO = 3'd4;

endpackage

// ===== design/irpt_if.sv =====
// Channel interfaces: command input, result output and configuration write.
interface irpt_in_if;
  logic                        valid;
  logic                        ready;
  logic [irpt_pkg::CmdW-1:0]    cmd;
  logic [irpt_pkg::CodeW-1:0]   code_value;
  logic [irpt_pkg::SlotW-1:0]   raw_slot;
  logic [irpt_pkg::DurW-1:0]    raw_duration;
  logic [irpt_pkg::RawLenW-1:0] raw_length;

  modport source(output valid, cmd, code_value, raw_slot, raw_duration, raw_length,
                 input ready);
  modport sink(input valid, cmd, code_value, raw_slot, raw_duration, raw_length,
               output ready);
endinterface

interface irpt_out_if;
  logic valid;
  logic ready;
  logic led_on;
  logic busy_res;
  logic accepted;

  modport source(output valid, led_on, busy_res, accepted, input ready);
  modport sink(input valid, led_on, busy_res, accepted, output ready);
endinterface

interface irpt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [irpt_pkg::CfgIdxW-1:0] index;
  logic [irpt_pkg::DurW-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== design/ir_pulse_train_emitter.sv =====
// IR pulse-train emitter: duration buffer, NEC/SKY fill sequencer and tick player.
//
// Usage:
//   in_i carries one command per beat: tick, NEC send, SKY send, raw entry write
//   or raw start. Every accepted beat yields exactly one result beat on out_o
//   (gate level, busy flag, accepted flag). cfg_i writes the eight 16-bit
//   timing registers and is always ready; write it only while idle.
// Sequence:
//   Idle ticks, raw writes and raw starts finish in the accept cycle. A tick while
//   playing goes through the tick state (buffer read, then compare/advance). NEC and
//   SKY sends step through the fill state with one buffer write per cycle.
//   The result beat is valid the cycle after the work ends. One item is in
//   flight at a time; in_i is ready again the cycle after the result is taken.
// Reset:
//   After rst_ni the block sweeps the buffer to zero, one entry per cycle,
//   before in_i goes ready.
//   Timing registers return to their defaults.
// Stall:
//   If out_o is not taken, the result is held and no new command is taken.
module ir_pulse_train_emitter #(
  parameter int unsigned BUFFER_DEPTH = irpt_pkg::BufferDepthDef,
  parameter int unsigned NEC_BITS     = irpt_pkg::NecBitsDef,
  parameter int unsigned SKY_BITS     = irpt_pkg::SkyBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  irpt_cfg_if.sink   cfg_i,
  irpt_in_if.sink    in_i,
  irpt_out_if.source out_o
);

  localparam int unsigned AddrW    = $clog2(BUFFER_DEPTH);
  localparam int unsigned LenW     = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned NecLen   = 2 * NEC_BITS + 4;
  localparam int unsigned SkyLen   = SKY_BITS + 7;
  localparam int unsigned FillMax  = (NecLen > SkyLen) ? NecLen : SkyLen;
  localparam int unsigned FillW    = $clog2(FillMax);
  localparam int unsigned NecBitHi = 2 * NEC_BITS + 1;  // last data space slot
  localparam int unsigned SkyBitLo = 6;
  localparam int unsigned SkyBitHi = SKY_BITS + 5;
  localparam int unsigned DurW     = irpt_pkg::DurW;

  // Sequencer states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_FILL  = 2'd2;
  localparam logic [1:0] ST_TICK  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [AddrW-1:0]       clr_q, clr_d;
  logic [DurW-1:0]        cfg_q [irpt_pkg::CfgCount];
  logic [irpt_pkg::CodeW-1:0] code_q, code_d;
  logic                   sky_q, sky_d;
  logic [FillW-1:0]       fill_idx_q, fill_idx_d;
  logic [LenW-1:0]        len_q, len_d;
  logic [LenW-1:0]        pos_q, pos_d;
  logic [DurW-1:0]        tick_q, tick_d;
  logic                   next_lvl_q, next_lvl_d;
  logic                   gate_q, gate_d;
  logic                   playing_q, playing_d;
  logic                   out_vld_q, out_vld_d;
  logic                   out_led_q, out_led_d;
  logic                   out_busy_q, out_busy_d;
  logic                   out_acc_q, out_acc_d;

  // Buffer memory and its port signals
  logic [DurW-1:0]        mem [BUFFER_DEPTH];
  logic [DurW-1:0]        rd_q;
  logic                   mem_we;
  logic [AddrW-1:0]       mem_waddr;
  logic [DurW-1:0]        mem_wdata;

  logic                   in_acc;
  logic                   fill_last;
  logic [DurW-1:0]        fill_val;
  logic                   fill_shift;
  logic                   gate_n;
  logic [LenW-1:0]        pos_n;

  assign cfg_i.ready    = 1'b1;
  assign in_i.ready     = (state_q == ST_IDLE) && !out_vld_q;
  assign in_acc         = in_i.valid && in_i.ready;
  assign out_o.valid    = out_vld_q;
  assign out_o.led_on   = out_led_q;
  assign out_o.busy_res = out_busy_q;
  assign out_o.accepted = out_acc_q;

  // Entry value for the current fill slot; also flags when the code shifts.
  always_comb begin
    fill_val   = cfg_q[irpt_pkg::CFG_SKY_ZERO];
    fill_shift = 1'b0;
    if (!sky_q) begin
      if (fill_idx_q == FillW'(0)) begin
        fill_val = cfg_q[irpt_pkg::CFG_NEC_LEAD_HIGH];
      end else if (fill_idx_q == FillW'(1)) begin
        fill_val = cfg_q[irpt_pkg::CFG_NEC_LEAD_LOW];
      end else if (!fill_idx_q[0]) begin
        fill_val = cfg_q[irpt_pkg::CFG_NEC_MARK];
      end else if (fill_idx_q <= FillW'(NecBitHi)) begin
        // Data space, MSB first: code shifts left after each bit
        fill_shift = 1'b1;
        fill_val   = code_q[NEC_BITS-1] ? cfg_q[irpt_pkg::CFG_NEC_SPACE_ONE]
                                        : cfg_q[irpt_pkg::CFG_NEC_SPACE_ZERO];
      end else begin
        fill_val = cfg_q[irpt_pkg::CFG_NEC_SPACE_ZERO];
      end
    end else begin
      if (fill_idx_q == FillW'(0)) begin
        fill_val = cfg_q[irpt_pkg::CFG_SKY_START];
      end else if (fill_idx_q <= FillW'(3)) begin
        fill_val = cfg_q[irpt_pkg::CFG_SKY_ONE];
      end else if (fill_idx_q >= FillW'(SkyBitLo) && fill_idx_q <= FillW'(SkyBitHi)) begin
        // Data entries, LSB first: code shifts right after each bit
        fill_shift = 1'b1;
        fill_val   = code_q[0] ? cfg_q[irpt_pkg::CFG_SKY_ONE]
                               : cfg_q[irpt_pkg::CFG_SKY_ZERO];
      end else begin
        fill_val = cfg_q[irpt_pkg::CFG_SKY_ZERO];
      end
    end
  end

  assign fill_last = sky_q ? (fill_idx_q == FillW'(SkyLen - 1))
                           : (fill_idx_q == FillW'(NecLen - 1));

  // Tick step: level change on first tick of an entry, advance at its end
  always_comb begin
    gate_n = gate_q;
    if (tick_q == '0) begin
      gate_n = next_lvl_q;
    end
    pos_n = pos_q + LenW'(1);
    if (tick_q == rd_q && pos_n >= len_q) begin
      gate_n = 1'b0;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    code_d     = code_q;
    sky_d      = sky_q;
    fill_idx_d = fill_idx_q;
    len_d      = len_q;
    pos_d      = pos_q;
    tick_d     = tick_q;
    next_lvl_d = next_lvl_q;
    gate_d     = gate_q;
    playing_d  = playing_q;
    out_vld_d  = out_vld_q;
    out_led_d  = out_led_q;
    out_busy_d = out_busy_q;
    out_acc_d  = out_acc_q;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == AddrW'(BUFFER_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AddrW'(1);
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          // Default: result right away, nothing taken
          out_vld_d  = 1'b1;
          out_led_d  = gate_q;
          out_busy_d = playing_q;
          out_acc_d  = 1'b0;
          case (in_i.cmd)
            irpt_pkg::CMD_TICK: begin
              if (playing_q) begin
                state_d   = ST_TICK;
                out_vld_d = 1'b0;
              end
            end
            irpt_pkg::CMD_NEC, irpt_pkg::CMD_SKY: begin
              if (!playing_q) begin
                state_d    = ST_FILL;
                sky_d      = (in_i.cmd == irpt_pkg::CMD_SKY);
                code_d     = in_i.code_value;
                fill_idx_d = '0;
                out_vld_d  = 1'b0;
              end
            end
            irpt_pkg::CMD_RAW_WR: begin
              if (!playing_q && (32'(in_i.raw_slot) < 32'(BUFFER_DEPTH))) begin
                mem_we    = 1'b1;
                mem_waddr = AddrW'(in_i.raw_slot);
                mem_wdata = in_i.raw_duration;
                out_acc_d = 1'b1;
              end
            end
            irpt_pkg::CMD_RAW_GO: begin
              if (!playing_q && in_i.raw_length != '0) begin
                len_d      = (32'(in_i.raw_length) > 32'(BUFFER_DEPTH))
                             ? LenW'(BUFFER_DEPTH) : LenW'(in_i.raw_length);
                pos_d      = '0;
                tick_d     = '0;
                next_lvl_d = 1'b1;
                playing_d  = 1'b1;
                out_busy_d = 1'b1;
                out_acc_d  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = AddrW'(fill_idx_q);
        mem_wdata = fill_val;
        if (fill_shift) begin
          code_d = sky_q ? (code_q >> 1) : (code_q << 1);
        end
        if (fill_last) begin
          len_d      = sky_q ? LenW'(SkyLen) : LenW'(NecLen);
          pos_d      = '0;
          tick_d     = '0;
          next_lvl_d = 1'b1;
          playing_d  = 1'b1;
          state_d    = ST_IDLE;
          out_vld_d  = 1'b1;
          out_led_d  = gate_q;
          out_busy_d = 1'b1;
          out_acc_d  = 1'b1;
        end else begin
          fill_idx_d = fill_idx_q + FillW'(1);
        end
      end

      ST_TICK: begin
        if (tick_q == '0) begin
          next_lvl_d = ~next_lvl_q;
        end
        if (tick_q == rd_q) begin
          tick_d = '0;
          pos_d  = pos_n;
          if (pos_n >= len_q) begin
            playing_d = 1'b0;
          end
        end else begin
          tick_d = tick_q + DurW'(1);
        end
        gate_d     = gate_n;
        state_d    = ST_IDLE;
        out_vld_d  = 1'b1;
        out_led_d  = gate_n;
        out_busy_d = !((tick_q == rd_q) && (pos_n >= len_q));
        out_acc_d  = 1'b0;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Buffer: one write port, read port addressed by the play position
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[pos_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      len_q      <= '0;
      pos_q      <= '0;
      tick_q     <= '0;
      next_lvl_q <= 1'b0;
      gate_q     <= 1'b0;
      playing_q  <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < irpt_pkg::CfgCount; i++) begin
        cfg_q[i] <= irpt_pkg::CFG_RESET[i];
      end
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      len_q      <= len_d;
      pos_q      <= pos_d;
      tick_q     <= tick_d;
      next_lvl_q <= next_lvl_d;
      gate_q     <= gate_d;
      playing_q  <= playing_d;
      out_vld_q  <= out_vld_d;
      if (cfg_i.valid) begin
        cfg_q[cfg_i.index] <= cfg_i.data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    code_q     <= code_d;
    sky_q      <= sky_d;
    fill_idx_q <= fill_idx_d;
    out_led_q  <= out_led_d;
    out_busy_q <= out_busy_d;
    out_acc_q  <= out_acc_d;
  end

endmodule

// ===== dv/ir_pulse_train_emitter_tb.sv =====
// Self-checking testbench for the IR pulse-train emitter: command stimulus, gate prediction.
module ir_pulse_train_emitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Field widths from the package
  localparam int unsigned CmdW    = irpt_pkg::CmdW;
  localparam int unsigned CodeW   = irpt_pkg::CodeW;
  localparam int unsigned SlotW   = irpt_pkg::SlotW;
  localparam int unsigned DurW    = irpt_pkg::DurW;
  localparam int unsigned RawLenW = irpt_pkg::RawLenW;
  localparam int unsigned CfgIdxW = irpt_pkg::CfgIdxW;

  // Run knobs
  localparam int unsigned WatchdogLimit = 4000;  // quiet cycles before giving up
  localparam int unsigned SettleCycles  = 80;    // idle wait before the final check
  localparam int unsigned IdlePct       = 11;    // per-cycle bubble chance, each side
  localparam int unsigned RandomItems   = 640;   // directed part adds roughly 600 more
  localparam int unsigned PhaseCount    = 4;

  // Top of the 3-bit command space; codes above CMD_RAW_GO are no-ops
  localparam logic [CmdW-1:0]    CMD_CODE_MAX = '1;
  localparam logic [RawLenW-1:0] RawLenMax    = '1;

  typedef struct packed {
    logic [CmdW-1:0]    cmd;
    logic [CodeW-1:0]   code_value;
    logic [SlotW-1:0]   raw_slot;
    logic [DurW-1:0]    raw_duration;
    logic [RawLenW-1:0] raw_length;
  } irpt_cmd_t;

  typedef struct packed {
    logic led_on;
    logic busy_res;
    logic accepted;
  } gate_beat_t;

  // Mirrors the emitter: duration buffer, player state and timing registers.
  // Each accepted command yields one expected gate beat.
  class pulse_train_scoreboard;
    logic [DurW-1:0]    timing    [irpt_pkg::CfgCount];
    logic [DurW-1:0]    durations [irpt_pkg::BufferDepthDef];
    logic [RawLenW-1:0] train_len;
    logic [RawLenW-1:0] play_idx;
    logic [DurW-1:0]    hold_cnt;
    logic               lvl_next;
    logic               gate;
    logic               active;
    gate_beat_t         expected_q [$];
    int unsigned        mismatches;

    function new();
      foreach (timing[i]) timing[i] = irpt_pkg::CFG_RESET[i];
      foreach (durations[i]) durations[i] = '0;
      train_len  = '0;
      play_idx   = '0;
      hold_cnt   = '0;
      lvl_next   = 1'b0;
      gate       = 1'b0;
      active     = 1'b0;
      mismatches = 0;
    endfunction

    function void set_timing(logic [CfgIdxW-1:0] idx, logic [DurW-1:0] val);
      timing[idx] = val;
    endfunction

    function void arm_train(logic [RawLenW-1:0] len);
      train_len = len;
      play_idx  = '0;
      hold_cnt  = '0;
      lvl_next  = 1'b1;
      active    = 1'b1;
    endfunction

    // Leader, 32 mark/space pairs MSB first, stop pair
    function void load_nec_train(logic [CodeW-1:0] code);
      int n;
      durations[0] = timing[irpt_pkg::CFG_NEC_LEAD_HIGH];
      durations[1] = timing[irpt_pkg::CFG_NEC_LEAD_LOW];
      n = 2;
      for (int b = irpt_pkg::NecBitsDef - 1; b >= 0; b--) begin
        durations[n]   = timing[irpt_pkg::CFG_NEC_MARK];
        durations[n+1] = code[b] ? timing[irpt_pkg::CFG_NEC_SPACE_ONE]
                                 : timing[irpt_pkg::CFG_NEC_SPACE_ZERO];
        n += 2;
      end
      durations[n]   = timing[irpt_pkg::CFG_NEC_MARK];
      durations[n+1] = timing[irpt_pkg::CFG_NEC_SPACE_ZERO];
      arm_train(RawLenW'(n + 2));
    endfunction

    // Start, 1-1-1-0-0 preamble, code bits LSB first, trailing zero
    function void load_sky_train(logic [CodeW-1:0] code);
      int n;
      durations[0] = timing[irpt_pkg::CFG_SKY_START];
      durations[1] = timing[irpt_pkg::CFG_SKY_ONE];
      durations[2] = timing[irpt_pkg::CFG_SKY_ONE];
      durations[3] = timing[irpt_pkg::CFG_SKY_ONE];
      durations[4] = timing[irpt_pkg::CFG_SKY_ZERO];
      durations[5] = timing[irpt_pkg::CFG_SKY_ZERO];
      n = 6;
      for (int b = 0; b < irpt_pkg::SkyBitsDef; b++) begin
        durations[n] = code[b] ? timing[irpt_pkg::CFG_SKY_ONE] : timing[irpt_pkg::CFG_SKY_ZERO];
        n++;
      end
      durations[n] = timing[irpt_pkg::CFG_SKY_ZERO];
      arm_train(RawLenW'(n + 1));
    endfunction

    // Entry of value D holds its level for D+1 ticks; gate drops at end of list
    function void play_tick();
      logic [DurW-1:0] cur;
      if (!active) return;
      if (hold_cnt == '0) begin
        gate     = lvl_next;
        lvl_next = ~lvl_next;
      end
      cur = (play_idx < irpt_pkg::BufferDepthDef) ? durations[play_idx[SlotW-1:0]] : '0;
      if (hold_cnt == cur) begin
        hold_cnt = '0;
        play_idx++;
        if (play_idx >= train_len) begin
          active = 1'b0;
          gate   = 1'b0;
        end
      end else begin
        hold_cnt++;
      end
    endfunction

    // Returns 1 when the command did real work (tick while playing, or taken)
    function bit note_command(irpt_cmd_t c);
      gate_beat_t exp;
      bit         took;
      bit         worked;
      took   = 1'b0;
      worked = active && (c.cmd == irpt_pkg::CMD_TICK);
      if (c.cmd == irpt_pkg::CMD_TICK) begin
        play_tick();
      end else if (!active) begin
        case (c.cmd)
          irpt_pkg::CMD_NEC: begin
            load_nec_train(c.code_value);
            took = 1'b1;
          end
          irpt_pkg::CMD_SKY: begin
            load_sky_train(c.code_value);
            took = 1'b1;
          end
          irpt_pkg::CMD_RAW_WR: begin
            durations[c.raw_slot] = c.raw_duration;
            took = 1'b1;
          end
          irpt_pkg::CMD_RAW_GO: begin
            if (c.raw_length != '0) begin
              arm_train((c.raw_length > irpt_pkg::BufferDepthDef)
                        ? RawLenW'(irpt_pkg::BufferDepthDef) : c.raw_length);
              took = 1'b1;
            end
          end
          default: ;
        endcase
      end
      exp.led_on   = gate;
      exp.busy_res = active;
      exp.accepted = took;
      expected_q.push_back(exp);
      return worked || took;
    endfunction

    function void check_beat(gate_beat_t got);
      gate_beat_t exp;
      if (expected_q.size() == 0) begin
        $error("result beat with no pending expectation");
        mismatches++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.led_on !== exp.led_on) begin
        $error("led_on: expected %0d, actual %0d", exp.led_on, got.led_on);
        mismatches++;
      end
      if (got.busy_res !== exp.busy_res) begin
        $error("busy_res: expected %0d, actual %0d", exp.busy_res, got.busy_res);
        mismatches++;
      end
      if (got.accepted !== exp.accepted) begin
        $error("accepted: expected %0d, actual %0d", exp.accepted, got.accepted);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  irpt_in_if  in_if ();
  irpt_out_if out_if ();
  irpt_cfg_if cfg_if ();

  ir_pulse_train_emitter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  pulse_train_scoreboard sb;
  bit          steady;       // suppresses bubbles on both sides
  int unsigned work_items;   // beats that did real work
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result sink: check the beat taken at this edge, then pick next ready
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      sb.check_beat(gate_beat_t'{out_if.led_on, out_if.busy_res, out_if.accepted});
    end
    out_if.ready <= steady || ($urandom_range(99) >= IdlePct);
  end

  // Watchdog: any handshake on any channel counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // All fields random; caller overrides what matters for the command
  function automatic irpt_cmd_t rand_fields(logic [CmdW-1:0] op);
    irpt_cmd_t c;
    c.cmd          = op;
    c.code_value   = $urandom;
    c.raw_slot     = SlotW'($urandom);
    c.raw_duration = DurW'($urandom);
    c.raw_length   = RawLenW'($urandom);
    return c;
  endfunction

  // Valid stays high after the beat; the next call either drives the next
  // command or drops valid for a bubble, so one NBA per edge at most.
  task automatic send_command(irpt_cmd_t c);
    while (!steady && ($urandom_range(99) < IdlePct)) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.cmd          <= c.cmd;
    in_if.code_value   <= c.code_value;
    in_if.raw_slot     <= c.raw_slot;
    in_if.raw_duration <= c.raw_duration;
    in_if.raw_length   <= c.raw_length;
    do @(posedge clk_i); while (!in_if.ready);
    if (sb.note_command(c)) work_items++;
  endtask

  // Tick until the train ends; some beats are commands that must bounce off busy
  task automatic play_out(int unsigned noise_pct);
    irpt_cmd_t c;
    while (sb.active) begin
      if ($urandom_range(99) < noise_pct) begin
        c = rand_fields(CmdW'($urandom_range(irpt_pkg::CMD_NEC, CMD_CODE_MAX)));
      end else begin
        c = rand_fields(irpt_pkg::CMD_TICK);
      end
      send_command(c);
    end
  endtask

  // Drop valid and wait for every expected beat; the block is then idle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Leaves cfg valid high; caller lowers it after the batch
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [DurW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_timing(idx, val);
  endtask

  task automatic program_timing(int unsigned hi);
    for (int i = 0; i < irpt_pkg::CfgCount; i++) begin
      cfg_write(CfgIdxW'(i), DurW'($urandom_range(0, hi)));
    end
  endtask

  // One well-formed sequence (send or raw load + start) played out, or noise
  task automatic run_sequence();
    irpt_cmd_t   c;
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 25) begin
      send_command(rand_fields(irpt_pkg::CMD_NEC));
    end else if (pick < 50) begin
      send_command(rand_fields(irpt_pkg::CMD_SKY));
    end else if (pick < 85) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        c = rand_fields(irpt_pkg::CMD_RAW_WR);
        // low slots get played; small durations keep trains short
        if ($urandom_range(99) < 70) c.raw_slot = SlotW'($urandom_range(0, 23));
        c.raw_duration = DurW'($urandom_range(0, 3));
        send_command(c);
      end
      c    = rand_fields(irpt_pkg::CMD_RAW_GO);
      pick = $urandom_range(99);
      if (pick < 85) begin
        c.raw_length = RawLenW'($urandom_range(1, 24));
      end else if (pick < 95) begin
        c.raw_length = RawLenW'($urandom_range(irpt_pkg::BufferDepthDef, RawLenMax));
      end else begin
        c.raw_length = '0;
      end
      send_command(c);
    end else begin
      c = rand_fields(CmdW'($urandom_range(irpt_pkg::CMD_TICK, CMD_CODE_MAX)));
      if (c.cmd == irpt_pkg::CMD_RAW_WR) c.raw_duration = DurW'($urandom_range(0, 3));
      send_command(c);
    end
    play_out(8);
  endtask

  initial begin
    irpt_cmd_t   c;
    int unsigned mark;
    int unsigned span [PhaseCount] = '{3, 1, 5, 2};

    sb                 = new();
    steady             = 1'b0;
    work_items         = 0;
    quiet_cycles       = 0;
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.cmd          = irpt_pkg::CMD_TICK;
    in_if.code_value   = '0;
    in_if.raw_slot     = '0;
    in_if.raw_duration = '0;
    in_if.raw_length   = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = irpt_pkg::CFG_NEC_LEAD_HIGH;
    cfg_if.data        = '0;
    out_if.ready       = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ---- Directed, short timing ----
    // idle tick, unused code, zero-length raw start: all no-ops
    send_command(rand_fields(irpt_pkg::CMD_TICK));
    send_command(rand_fields(CMD_CODE_MAX));
    c = rand_fields(irpt_pkg::CMD_RAW_GO);
    c.raw_length = '0;
    send_command(c);
    drain();

    // short entries keep the directed trains within the item budget
    program_timing(3);
    cfg_if.valid <= 1'b0;

    // SKY with garbage above the low 12 bits, then commands while busy
    c = rand_fields(irpt_pkg::CMD_SKY);
    c.code_value = 32'hFFFF_FA5C;
    send_command(c);
    send_command(rand_fields(irpt_pkg::CMD_NEC));
    send_command(rand_fields(irpt_pkg::CMD_RAW_WR));
    c = rand_fields(irpt_pkg::CMD_RAW_GO);
    c.raw_length = RawLenW'(irpt_pkg::BufferDepthDef);
    send_command(c);
    play_out(0);

    c = rand_fields(irpt_pkg::CMD_NEC);
    c.code_value = 32'h8000_0001;
    send_command(c);
    play_out(0);
    drain();

    // ---- Directed, all timing registers at zero ----
    program_timing(0);
    cfg_if.valid <= 1'b0;

    c = rand_fields(irpt_pkg::CMD_NEC);
    c.code_value = '1;
    send_command(c);
    play_out(0);
    c = rand_fields(irpt_pkg::CMD_SKY);
    c.code_value = '0;
    send_command(c);
    play_out(0);

    // raw extremes: slot 0, top slot with max duration then rewritten small
    c = rand_fields(irpt_pkg::CMD_RAW_WR);
    c.raw_slot     = '0;
    c.raw_duration = DurW'(1);
    send_command(c);
    c.raw_slot     = '1;
    c.raw_duration = '1;
    send_command(c);
    c.raw_duration = DurW'(3);
    send_command(c);
    c = rand_fields(irpt_pkg::CMD_RAW_GO);
    c.raw_length = RawLenW'(1);
    send_command(c);
    play_out(0);
    // over-long raw length saturates to the full buffer
    c.raw_length = RawLenMax;
    send_command(c);
    play_out(0);
    drain();

    // ---- Random phases, each with its own timing set ----
    for (int ph = 0; ph < PhaseCount; ph++) begin
      drain();
      steady = (ph == 1);  // one long stretch with no bubbles
      program_timing(span[ph]);
      cfg_if.valid <= 1'b0;
      mark = work_items;
      while (work_items - mark < RandomItems / PhaseCount) run_sequence();
    end
    steady = 1'b0;

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/irpt_pkg.sv
design/irpt_if.sv
design/ir_pulse_train_emitter.sv
dv/ir_pulse_train_emitter_tb.sv
